// ----- src/ssgp_pkg.sv -----
// Package with the shared constants and the controller/datapath interface types.
`timescale 1ns / 1ps

package ssgp_pkg;

	localparam int MAX_REQUESTS_DEF = 16;

	localparam int KIND_W  = 8;
	localparam int CELLS_W = 8;
	localparam int AIDX_W  = 4;
	localparam int POOL_W  = 8;
	localparam int LIMIT_W = 5;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_CAPACITY = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PLACED    = 8'd1;

	localparam logic [POOL_W-1:0]  POOL_CAPACITY_RST = 8'd16;
	localparam logic [LIMIT_W-1:0] MAX_PLACED_RST    = 5'd16;

	typedef struct packed {
		logic load;
		logic init;
		logic scan_start;
		logic issue;
		logic decide;
		logic finish;
	} ssgp_cmd_t;

	typedef struct packed {
		logic max_zero;
		logic addr_live;
		logic best_valid;
		logic fit;
		logic done_after;
		logic pend_valid;
		logic out_free;
	} ssgp_stat_t;

endpackage

// ----- src/ssgp_ctrl.sv -----
// Controller state machine that sequences loading, sorting scans, the greedy walk and output.
`timescale 1ns / 1ps

module ssgp_ctrl
	import ssgp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_tvalid,
	input  logic       in_tlast,
	output logic       in_tready,
	input  ssgp_stat_t stat,
	output ssgp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_SCAN,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_tready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_tready = 1'b1;
				cmd.load = in_tvalid;
				if (in_tvalid && in_tlast) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				cmd.scan_start = 1'b1;
				state_d = stat.max_zero ? ST_FINISH : ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.addr_live) begin
					cmd.issue = 1'b1;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!stat.best_valid) begin
					state_d = ST_FINISH;
				end else if (!(stat.fit && stat.pend_valid && !stat.out_free)) begin
					cmd.decide = 1'b1;
					if (stat.fit && stat.done_after) begin
						state_d = ST_FINISH;
					end else begin
						cmd.scan_start = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// At most one of load, issue, decide and finish is commanded in any cycle; scan_start may come with init or decide.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.issue, cmd.decide, cmd.finish}))
		else $error("ssgp_ctrl: conflicting datapath commands");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == ST_LOAD)
		else $error("ssgp_ctrl: finish did not return to loading");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && in_tlast) |=> cmd.init)
		else $error("ssgp_ctrl: last request did not start the walk");

endmodule

// ----- src/ssgp_dp.sv -----
// Datapath with the request store, sort scan, greedy pool bookkeeping and output register.
`timescale 1ns / 1ps

module ssgp_dp
	import ssgp_pkg::*;
#(
	parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [KIND_W-1:0]     in_kind,
	input  logic [CELLS_W-1:0]    in_cells,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [KIND_W-1:0]     out_kind,
	output logic [CELLS_W-1:0]    out_cells,
	output logic [AIDX_W-1:0]     out_aidx,
	output logic                  out_none,
	output logic                  out_ovf,
	output logic                  out_last,
	input  ssgp_cmd_t             cmd,
	output ssgp_stat_t            stat
);

	localparam int IW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQUESTS);

	logic [KIND_W-1:0]  mem_kind [MAX_REQUESTS];
	logic [CELLS_W-1:0] mem_cells [MAX_REQUESTS];

	logic [POOL_W-1:0]  pool_cap_q;
	logic [LIMIT_W-1:0] max_placed_q;

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] addr_q;

	logic               rd_v_s1;
	logic [IW-1:0]      rd_idx_s1;
	logic [KIND_W-1:0]  rd_kind_s1;
	logic [CELLS_W-1:0] rd_cells_s1;

	logic               have_prev_q;
	logic [KIND_W-1:0]  prev_kind_q;
	logic [IW-1:0]      prev_idx_q;
	logic               best_valid_q;
	logic [KIND_W-1:0]  best_kind_q;
	logic [IW-1:0]      best_idx_q;
	logic [CELLS_W-1:0] best_cells_q;

	logic [POOL_W-1:0]  remaining_q;
	logic [LIMIT_W-1:0] placed_q;

	logic               pend_valid_q;
	logic [KIND_W-1:0]  pend_kind_q;
	logic [IW-1:0]      pend_idx_q;
	logic [CELLS_W-1:0] pend_cells_q;

	logic                  out_valid_q;
	logic [KIND_W-1:0]     out_kind_q;
	logic [CELLS_W-1:0]    out_cells_q;
	logic [AIDX_W-1:0]     out_aidx_q;
	logic                  out_none_q;
	logic                  out_ovf_q;
	logic                  out_last_q;

	logic [KIND_W+IW-1:0] cand_key;
	logic [KIND_W+IW-1:0] prev_key;
	logic [KIND_W+IW-1:0] best_key;
	logic                 cand_take;
	logic [POOL_W-1:0]    remaining_after;
	logic [LIMIT_W-1:0]   placed_after;
	logic                 fit;
	logic                 out_free;
	logic                 emit_pend_mid;
	logic [AIDX_W-1:0]    pend_aidx;

	assign cand_key = {rd_kind_s1, rd_idx_s1};
	assign prev_key = {prev_kind_q, prev_idx_q};
	assign best_key = {best_kind_q, best_idx_q};
	assign cand_take = rd_v_s1 && (!have_prev_q || (cand_key > prev_key))
		&& (!best_valid_q || (cand_key < best_key));

	assign fit = best_valid_q && (best_cells_q != '0) && (best_cells_q <= remaining_q);
	assign remaining_after = remaining_q - best_cells_q;
	assign placed_after = placed_q + LIMIT_W'(1);
	assign out_free = !out_valid_q || out_ready;
	assign emit_pend_mid = cmd.decide && fit && pend_valid_q;

	// The arrival index is carried at the width of the result field.
	always_comb begin
		pend_aidx = '0;
		pend_aidx[((IW < AIDX_W) ? IW : AIDX_W)-1:0] =
			pend_idx_q[((IW < AIDX_W) ? IW : AIDX_W)-1:0];
	end

	assign stat.max_zero   = (max_placed_q == '0);
	assign stat.addr_live  = (addr_q < count_q);
	assign stat.best_valid = best_valid_q;
	assign stat.fit        = fit;
	assign stat.done_after = (remaining_after == '0) || (placed_after == max_placed_q);
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free   = out_free;

	always_ff @(posedge clk) begin
		if (cmd.load && (count_q < MAX_CNT)) begin
			mem_kind[count_q[IW-1:0]]  <= in_kind;
			mem_cells[count_q[IW-1:0]] <= in_cells;
		end
		rd_kind_s1  <= mem_kind[addr_q[IW-1:0]];
		rd_cells_s1 <= mem_cells[addr_q[IW-1:0]];
		rd_idx_s1   <= addr_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_cap_q   <= POOL_CAPACITY_RST;
			max_placed_q <= MAX_PLACED_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_POOL_CAPACITY) begin
				pool_cap_q <= cfg_data;
			end else if (cfg_index == REG_MAX_PLACED) begin
				max_placed_q <= cfg_data[LIMIT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			ovf_q        <= 1'b0;
			addr_q       <= '0;
			rd_v_s1      <= 1'b0;
			have_prev_q  <= 1'b0;
			best_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
			remaining_q  <= '0;
			placed_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.issue;
			if (cmd.load) begin
				if (count_q < MAX_CNT) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.init) begin
				remaining_q  <= pool_cap_q;
				placed_q     <= '0;
				have_prev_q  <= 1'b0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.scan_start) begin
				addr_q       <= '0;
				best_valid_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					addr_q <= addr_q + CW'(1);
				end
				if (cand_take) begin
					best_valid_q <= 1'b1;
				end
			end
			if (cmd.decide) begin
				have_prev_q <= 1'b1;
				if (fit) begin
					remaining_q  <= remaining_after;
					placed_q     <= placed_after;
					pend_valid_q <= 1'b1;
				end
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_pend_mid || cmd.finish) begin
				out_valid_q <= 1'b1;
			end
			if (cmd.finish) begin
				count_q      <= '0;
				ovf_q        <= 1'b0;
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cand_take && !cmd.scan_start) begin
			best_kind_q  <= rd_kind_s1;
			best_idx_q   <= rd_idx_s1;
			best_cells_q <= rd_cells_s1;
		end
		if (cmd.decide) begin
			prev_kind_q <= best_kind_q;
			prev_idx_q  <= best_idx_q;
			if (fit) begin
				pend_kind_q  <= best_kind_q;
				pend_idx_q   <= best_idx_q;
				pend_cells_q <= best_cells_q;
			end
		end
		if (emit_pend_mid || (cmd.finish && pend_valid_q)) begin
			out_kind_q  <= pend_kind_q;
			out_cells_q <= pend_cells_q;
			out_aidx_q  <= pend_aidx;
			out_none_q  <= 1'b0;
			out_ovf_q   <= ovf_q;
			out_last_q  <= cmd.finish;
		end else if (cmd.finish) begin
			out_kind_q  <= '0;
			out_cells_q <= '0;
			out_aidx_q  <= '0;
			out_none_q  <= 1'b1;
			out_ovf_q   <= ovf_q;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_cells = out_cells_q;
	assign out_aidx  = out_aidx_q;
	assign out_none  = out_none_q;
	assign out_ovf   = out_ovf_q;
	assign out_last  = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("ssgp_dp: request count beyond the store depth");

	// A placement never overwrites a result that the output side has not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit_pend_mid || cmd.finish) |-> out_free)
		else $error("ssgp_dp: result loaded into a busy output register");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (out_valid_q && out_last_q && (out_none_q == !$past(pend_valid_q))))
		else $error("ssgp_dp: batch close did not present the final result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && fit) |=> (placed_q <= max_placed_q))
		else $error("ssgp_dp: placed count passed the limit");

endmodule

// ----- src/stable_sort_greedy_pool_fill_unit.sv -----
// Top level of the stable-sort greedy pool fill unit.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                 Contents
// s_axis    in         s_axis_tvalid/tready      request: kind, cells; tlast ends the batch
// m_axis    out        m_axis_tvalid/tready      placed request, tuser = none_placed
// cfg       in         cfg_valid/cfg_ready       register index and write data
//
// Requests are taken while the batch loads; a setup step then starts the walk.
// Each next stored entry in sorted order is found by a scan over the stored entries and
// then a decision; a walk that runs out of entries ends with a scan that finds none, and
// a closing step ends the batch. With max_placed at zero the walk is skipped.
// A stalled output holds the walk at its next placement. Requests and register writes wait
// until the batch is closed. Reset empties the batch and loads the default register values.

module stable_sort_greedy_pool_fill_unit
	import ssgp_pkg::*;
#(
	parameter int MAX_REQUESTS = MAX_REQUESTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata, // kind [7:0], cells [15:8]
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// placed_kind [7:0], placed_cells [15:8], arrival_index [19:16], overflow [20], zero fill
	output logic [23:0]           m_axis_tdata,
	output logic                  m_axis_tuser, // none_placed [0]
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ssgp_cmd_t  cmd;
	ssgp_stat_t stat;

	logic [KIND_W-1:0]  out_kind;
	logic [CELLS_W-1:0] out_cells;
	logic [AIDX_W-1:0]  out_aidx;
	logic               out_ovf;

	// Register writes are taken only while requests are being loaded.
	assign cfg_ready = s_axis_tready;

	ssgp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tlast  (s_axis_tlast),
		.in_tready (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ssgp_dp #(
		.MAX_REQUESTS (MAX_REQUESTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_kind   (s_axis_tdata[7:0]),
		.in_cells  (s_axis_tdata[15:8]),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_kind  (out_kind),
		.out_cells (out_cells),
		.out_aidx  (out_aidx),
		.out_none  (m_axis_tuser),
		.out_ovf   (out_ovf),
		.out_last  (m_axis_tlast),
		.cmd       (cmd),
		.stat      (stat)
	);

	assign m_axis_tdata = {3'b000, out_ovf, out_aidx, out_cells, out_kind};

endmodule
